// File: rtl/view_priority_lru_slot_replacer_top_assert.svh
`ifndef VIEW_PRIORITY_LRU_SLOT_REPLACER_TOP_ASSERT_SVH
`define VIEW_PRIORITY_LRU_SLOT_REPLACER_TOP_ASSERT_SVH
// assertion helpers
`define VPL_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("lbl failed");
`define VPL_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("lbl failed");
`endif

// File: rtl/vplsr_pkg.sv
package vplsr_pkg;
  localparam logic [2:0] FUNC_ALLOC    = 3'd0;
  localparam logic [2:0] FUNC_RELEASE  = 3'd1;
  localparam logic [2:0] FUNC_PRESERVE = 3'd2;
  localparam logic [2:0] FUNC_VIEW     = 3'd3;
  localparam logic [2:0] FUNC_DISCARD  = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
  } vplsr_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic needs_scan;
  } vplsr_sts_t;
endpackage

// File: rtl/view_priority_lru_slot_replacer_top.sv
// Tile slot pool with view-aware LRU replacement, one request at a time. A hit, a free slot
// or any non-allocate request passes from IDLE through CHECK to DONE; an allocate that must
// evict also passes through SCAN, which scans one slot per cycle. The controller is idle
// again right after the result is written in DONE, and only then takes the next request.
// The result sits in an output register until taken; the next request may be accepted
// meanwhile, but its result waits for that register to drain.
module view_priority_lru_slot_replacer_top #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_ZOOMS = 3,
  parameter int TILE_EDGE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[2:0] zoom[4:3] tile_column[13:5] tile_row[22:14] slot_number[26:23]
  // view_left[41:27] view_top[56:42] view_right[71:57] view_bottom[86:72]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // chosen_slot[3:0] hit[4] replaced[5] status[6]
  output logic [7:0]  out_tdata
);
  vplsr_pkg::vplsr_cmd_t cmd;
  vplsr_pkg::vplsr_sts_t sts;
  logic out_valid_r;
  logic [3:0] cs;
  logic h, rp, st;

  vplsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_busy(out_valid_r && !out_tready), .sts(sts), .in_ready(in_tready), .cmd(cmd)
  );

  vplsr_dp #(.NUM_SLOTS(NUM_SLOTS), .NUM_ZOOMS(NUM_ZOOMS), .TILE_EDGE(TILE_EDGE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .func(in_tdata[2:0]), .zoom(in_tdata[4:3]), .tile_column(in_tdata[13:5]),
    .tile_row(in_tdata[22:14]), .slot_number(in_tdata[26:23]),
    .view_left(in_tdata[41:27]), .view_top(in_tdata[56:42]),
    .view_right(in_tdata[71:57]), .view_bottom(in_tdata[86:72]),
    .sts(sts), .chosen_slot(cs), .hit(h), .replaced(rp), .status(st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.commit) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, st, rp, h, cs};
endmodule

// File: rtl/vplsr_ctrl.sv
module vplsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_busy,
  input  vplsr_pkg::vplsr_sts_t sts,
  output logic                in_ready,
  output vplsr_pkg::vplsr_cmd_t cmd
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_CHECK = 4'b0010, ST_SCAN = 4'b0100, ST_DONE = 4'b1000
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.needs_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

`include "view_priority_lru_slot_replacer_top_assert.svh"
  `VPL_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `VPL_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, !out_busy)
  `VPL_ASSERT_NXT(a_load_busy, clk, rst_n, cmd.load, !in_ready)
endmodule

// File: rtl/vplsr_dp.sv
module vplsr_dp #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_ZOOMS = 3,
  parameter int TILE_EDGE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vplsr_pkg::vplsr_cmd_t cmd,
  input  logic [2:0]            func,
  input  logic [1:0]            zoom,
  input  logic [8:0]            tile_column,
  input  logic [8:0]            tile_row,
  input  logic [3:0]            slot_number,
  input  logic [14:0]           view_left,
  input  logic [14:0]           view_top,
  input  logic [14:0]           view_right,
  input  logic [14:0]           view_bottom,
  output vplsr_pkg::vplsr_sts_t sts,
  output logic [3:0]            chosen_slot,
  output logic                  hit,
  output logic                  replaced,
  output logic                  status
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW = $clog2(TILE_EDGE);
  localparam int CW = 9 + TW + 1;

  logic [NUM_SLOTS-1:0] occ_r, pres_r;
  logic [19:0] key_r [NUM_SLOTS];
  logic [31:0] stamp_r [NUM_SLOTS];
  logic [31:0] ctr_r;
  logic [14:0] fl_r [NUM_ZOOMS], ft_r [NUM_ZOOMS], fr_r [NUM_ZOOMS], fb_r [NUM_ZOOMS];
  logic [NUM_ZOOMS-1:0] fv_r;
  logic [1:0] az_r;

  logic [2:0] func_r;
  logic [1:0] zoom_r;
  logic [19:0] rkey_r;
  logic [3:0] sn_r;
  logic [14:0] vl_r, vt_r, vr_r, vb_r;

  logic [SW-1:0] idx_r, best_r;
  logic [1:0] brank_r;
  logic [31:0] bstamp_r;
  logic found_r;

  logic [NUM_SLOTS-1:0] match_v, free_v;
  logic any_match, any_free, any_pres;
  logic [SW-1:0] match_i, free_i;
  logic [31:0] ctr_inc;
  assign ctr_inc = ctr_r + 32'd1;

  always_comb begin
    match_i = '0;
    free_i = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      match_v[i] = occ_r[i] && key_r[i] == rkey_r;
      free_v[i] = !occ_r[i] && !pres_r[i];
      if (match_v[i]) match_i = SW'(i);
      if (free_v[i]) free_i = SW'(i);
    end
  end
  assign any_match = |match_v;
  assign any_free = |free_v;
  assign any_pres = |pres_r;
  assign sts.needs_scan = func_r == vplsr_pkg::FUNC_ALLOC && !any_match && !any_free;
  assign sts.scan_last = idx_r == SW'(NUM_SLOTS - 1);

  logic [1:0] kz;
  logic [8:0] kc, kr;
  logic [CW-1:0] x0, y0, x1, y1;
  logic [1:0] rank;
  logic [31:0] cur_stamp;
  logic cur_pres, better;
  always_comb begin
    kz = key_r[idx_r][19:18];
    kc = key_r[idx_r][17:9];
    kr = key_r[idx_r][8:0];
    x0 = CW'(kc) * CW'(TILE_EDGE);
    y0 = CW'(kr) * CW'(TILE_EDGE);
    x1 = x0 + CW'(TILE_EDGE);
    y1 = y0 + CW'(TILE_EDGE);
    rank = 2'd0;
    for (int z = 0; z < NUM_ZOOMS; z++) begin
      if (kz == 2'(z + 1) && fv_r[z] && x0 < CW'(fr_r[z]) && y0 < CW'(fb_r[z])
          && x1 > CW'(fl_r[z]) && y1 > CW'(ft_r[z]))
        rank = (kz == az_r) ? 2'd2 : 2'd1;
    end
    cur_stamp = stamp_r[idx_r];
    cur_pres = pres_r[idx_r];
    if (any_pres) better = cur_pres && (!found_r || cur_stamp < bstamp_r);
    else better = !found_r || rank < brank_r || (rank == brank_r && cur_stamp < bstamp_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      zoom_r <= zoom;
      rkey_r <= {zoom, tile_column, tile_row};
      sn_r <= slot_number;
      vl_r <= view_left;
      vt_r <= view_top;
      vr_r <= view_right;
      vb_r <= view_bottom;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (better) begin
        best_r <= idx_r;
        brank_r <= rank;
        bstamp_r <= cur_stamp;
        found_r <= 1'b1;
      end
      if (!sts.scan_last) idx_r <= idx_r + SW'(1);
    end
  end

  logic [SW-1:0] alloc_s;
  logic vz_ok, sn_ok;
  logic [3:0] res_cs;
  logic res_hit, res_rep, res_st;
  assign alloc_s = any_match ? match_i : (any_free ? free_i : best_r);
  assign vz_ok = zoom_r != 2'd0 && 32'(zoom_r) <= NUM_ZOOMS && vr_r > vl_r && vb_r > vt_r;
  assign sn_ok = 32'(sn_r) < NUM_SLOTS;

  always_comb begin
    res_cs = '0;
    res_hit = 1'b0;
    res_rep = 1'b0;
    res_st = 1'b0;
    case (func_r)
      vplsr_pkg::FUNC_ALLOC: begin
        res_cs = 4'(alloc_s);
        res_hit = any_match;
        res_rep = !any_match && (occ_r[alloc_s] || pres_r[alloc_s]);
      end
      vplsr_pkg::FUNC_RELEASE: begin
        if (any_match) res_cs = 4'(match_i);
        else res_st = 1'b1;
      end
      vplsr_pkg::FUNC_PRESERVE: begin
        if (sn_ok) res_cs = sn_r;
        else res_st = 1'b1;
      end
      vplsr_pkg::FUNC_VIEW: res_st = !vz_ok;
      vplsr_pkg::FUNC_DISCARD: res_st = 1'b0;
      default: res_st = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      pres_r <= '0;
      fv_r <= '0;
      az_r <= '0;
      ctr_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) stamp_r[i] <= '0;
    end else if (cmd.commit) begin
      chosen_slot <= res_cs;
      hit <= res_hit;
      replaced <= res_rep;
      status <= res_st;
      case (func_r)
        vplsr_pkg::FUNC_ALLOC: begin
          if (!any_match) key_r[alloc_s] <= rkey_r;
          occ_r[alloc_s] <= 1'b1;
          pres_r[alloc_s] <= 1'b0;
          ctr_r <= ctr_inc;
          stamp_r[alloc_s] <= ctr_inc;
        end
        vplsr_pkg::FUNC_RELEASE: begin
          if (any_match) occ_r[match_i] <= 1'b0;
        end
        vplsr_pkg::FUNC_PRESERVE: begin
          if (sn_ok) begin
            occ_r[SW'(sn_r)] <= 1'b0;
            pres_r[SW'(sn_r)] <= 1'b1;
            ctr_r <= ctr_inc;
            stamp_r[SW'(sn_r)] <= ctr_inc;
          end
        end
        vplsr_pkg::FUNC_VIEW: begin
          if (vz_ok) begin
            for (int z = 0; z < NUM_ZOOMS; z++) begin
              if (zoom_r == 2'(z + 1)) begin
                fl_r[z] <= vl_r;
                ft_r[z] <= vt_r;
                fr_r[z] <= vr_r;
                fb_r[z] <= vb_r;
                fv_r[z] <= 1'b1;
              end
            end
            az_r <= zoom_r;
          end
        end
        vplsr_pkg::FUNC_DISCARD: begin
          occ_r <= '0;
          pres_r <= '0;
        end
        default: ;
      endcase
    end
  end

`include "view_priority_lru_slot_replacer_top_assert.svh"
  `VPL_ASSERT_IMP(a_no_both, clk, rst_n, 1'b1, (occ_r & pres_r) == '0)
  `VPL_ASSERT_NXT(a_ctr_step, clk, rst_n, cmd.commit && func_r == vplsr_pkg::FUNC_ALLOC,
    ctr_r == $past(ctr_r) + 32'd1)
  `VPL_ASSERT_IMP(a_scan_excl, clk, rst_n, cmd.scan_step, !cmd.commit && !cmd.load)
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  localparam int NSLOT = 16;
  localparam int NZOOM = 3;
  localparam int EDGE = 64;
  localparam logic [2:0] FUNC_BAD5 = 3'd5;
  localparam logic [2:0] FUNC_BAD7 = 3'd7;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [3:0] chosen;
    logic       hit;
    logic       replaced;
    logic       refused;
  } grant_t;

  typedef struct {
    logic [2:0]  func;
    logic [1:0]  zoom;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [3:0]  slot;
    logic [14:0] vl, vt, vr, vb;
  } req_t;

  typedef struct {
    req_t   rq;
    bit     typed;
    grant_t want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [7:0] out_tdata;

  always #6 clk = ~clk;

  view_priority_lru_slot_replacer_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  bit          occ[NSLOT];
  bit          pres[NSLOT];
  logic [19:0] key_of[NSLOT];
  logic [31:0] stamp[NSLOT];
  logic [31:0] use_count;
  logic [14:0] fp[NZOOM][4];
  bit          fp_ok[NZOOM];
  logic [1:0]  act_zoom;

  grant_t grants_due[$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit sending_done = 0;

  function automatic logic [1:0] rank_of(logic [19:0] k);
    logic [1:0] z;
    logic [31:0] x0, y0;
    z = k[19:18];
    if (z == 0 || z > NZOOM || !fp_ok[z-1]) return 2'd0;
    x0 = k[17:9] * EDGE;
    y0 = k[8:0] * EDGE;
    if (x0 >= fp[z-1][2] || y0 >= fp[z-1][3] || x0 + EDGE <= fp[z-1][0] ||
        y0 + EDGE <= fp[z-1][1]) return 2'd0;
    return (z == act_zoom) ? 2'd2 : 2'd1;
  endfunction

  function automatic int victim_slot();
    int best;
    logic [1:0] br, rk;
    bit found;
    best = 0;
    br = 2'd3;
    found = 0;
    for (int i = 0; i < NSLOT; i++) if (!occ[i] && !pres[i]) return i;
    for (int i = 0; i < NSLOT; i++)
      if (pres[i] && (!found || stamp[i] < stamp[best])) begin
        best = i;
        found = 1;
      end
    if (found) return best;
    best = 0;
    for (int i = 0; i < NSLOT; i++) begin
      rk = rank_of(key_of[i]);
      if (rk < br || (rk == br && stamp[i] < stamp[best])) begin
        best = i;
        br = rk;
      end
    end
    return best;
  endfunction

  function automatic int lookup(logic [19:0] k);
    for (int i = 0; i < NSLOT; i++) if (occ[i] && key_of[i] == k) return i;
    return -1;
  endfunction

  function automatic grant_t serve(req_t rq);
    grant_t g;
    logic [19:0] k;
    int s;
    g = '0;
    k = {rq.zoom, rq.col, rq.row};
    case (rq.func)
      vplsr_pkg::FUNC_ALLOC: begin
        s = lookup(k);
        if (s >= 0) g.hit = 1;
        else begin
          s = victim_slot();
          g.replaced = occ[s] || pres[s];
          key_of[s] = k;
          pres[s] = 0;
          occ[s] = 1;
        end
        use_count++;
        stamp[s] = use_count;
        g.chosen = 4'(s);
      end
      vplsr_pkg::FUNC_RELEASE: begin
        s = lookup(k);
        if (s >= 0) begin
          occ[s] = 0;
          g.chosen = 4'(s);
        end else g.refused = 1;
      end
      vplsr_pkg::FUNC_PRESERVE: begin
        occ[rq.slot] = 0;
        pres[rq.slot] = 1;
        use_count++;
        stamp[rq.slot] = use_count;
        g.chosen = rq.slot;
      end
      vplsr_pkg::FUNC_VIEW: begin
        if (rq.zoom == 0 || rq.zoom > NZOOM || rq.vr <= rq.vl || rq.vb <= rq.vt)
          g.refused = 1;
        else begin
          fp[rq.zoom-1] = '{rq.vl, rq.vt, rq.vr, rq.vb};
          fp_ok[rq.zoom-1] = 1;
          act_zoom = rq.zoom;
        end
      end
      vplsr_pkg::FUNC_DISCARD: begin
        for (int i = 0; i < NSLOT; i++) begin
          occ[i] = 0;
          pres[i] = 0;
        end
      end
      default: g.refused = 1;
    endcase
    return g;
  endfunction

  function automatic req_t mk(logic [2:0] f, logic [1:0] z, logic [8:0] c, logic [8:0] r,
                              logic [3:0] s, logic [14:0] l, logic [14:0] t,
                              logic [14:0] rr, logic [14:0] b);
    req_t q;
    q.func = f; q.zoom = z; q.col = c; q.row = r; q.slot = s;
    q.vl = l; q.vt = t; q.vr = rr; q.vb = b;
    return q;
  endfunction

  function automatic grant_t gr(logic [3:0] c, logic h, logic rp, logic st);
    return '{chosen: c, hit: h, replaced: rp, refused: st};
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int p;
    q = mk(vplsr_pkg::FUNC_ALLOC, 2'($urandom), 9'($urandom_range(0, 5)),
           9'($urandom_range(0, 5)), 4'($urandom), 15'($urandom), 15'($urandom),
           15'($urandom), 15'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      q.col = 9'($urandom);
      q.row = 9'($urandom);
    end
    p = $urandom_range(0, 99);
    if (p < 55) q.func = vplsr_pkg::FUNC_ALLOC;
    else if (p < 72) q.func = vplsr_pkg::FUNC_RELEASE;
    else if (p < 80) q.func = vplsr_pkg::FUNC_PRESERVE;
    else if (p < 93) begin
      q.func = vplsr_pkg::FUNC_VIEW;
      if ($urandom_range(0, 3) != 0) begin
        q.vl = 15'($urandom_range(0, 300));
        q.vt = 15'($urandom_range(0, 300));
        q.vr = q.vl + 15'($urandom_range(1, 300));
        q.vb = q.vt + 15'($urandom_range(1, 300));
      end
    end else if (p < 96) q.func = vplsr_pkg::FUNC_DISCARD;
    else q.func = 3'($urandom_range(5, 7));
    return q;
  endfunction

  task automatic send(req_t q);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {1'b0, q.vb, q.vr, q.vt, q.vl, q.slot, q.row, q.col, q.zoom, q.func};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    grants_due.push_back(serve(q));
  endtask

  row_t plan[$];

  initial begin
    int k;
    for (int i = 0; i < NSLOT; i++) begin
      occ[i] = 0; pres[i] = 0; key_of[i] = 0; stamp[i] = 0;
    end
    for (int z = 0; z < NZOOM; z++) fp_ok[z] = 0;
    use_count = 0;
    act_zoom = 0;

    plan.push_back('{mk(vplsr_pkg::FUNC_ALLOC, 3, 511, 511, 15, 0, 0, 0, 0), 1,
                     gr(0, 0, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_ALLOC, 3, 511, 511, 0, 0, 0, 0, 0), 1,
                     gr(0, 1, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0), 1, gr(1, 0, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_RELEASE, 1, 7, 7, 0, 0, 0, 0, 0), 1,
                     gr(0, 0, 0, 1)});
    plan.push_back('{mk(vplsr_pkg::FUNC_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     gr(1, 0, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_PRESERVE, 0, 0, 0, 15, 0, 0, 0, 0), 1,
                     gr(15, 0, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_VIEW, 0, 0, 0, 0, 0, 0, 100, 100), 1,
                     gr(0, 0, 0, 1)});
    plan.push_back('{mk(vplsr_pkg::FUNC_VIEW, 1, 0, 0, 0, 50, 0, 50, 100), 1,
                     gr(0, 0, 0, 1)});
    plan.push_back('{mk(vplsr_pkg::FUNC_VIEW, 2, 0, 0, 0, 0, 70, 100, 70), 1,
                     gr(0, 0, 0, 1)});
    plan.push_back('{mk(vplsr_pkg::FUNC_VIEW, 3, 0, 0, 0, 0, 0, 32767, 32767), 1,
                     gr(0, 0, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_VIEW, 1, 0, 0, 0, 0, 0, 128, 128), 1,
                     gr(0, 0, 0, 0)});
    plan.push_back('{mk(FUNC_BAD5, 3, 511, 511, 15, 32767, 32767, 32767, 32767), 1,
                     gr(0, 0, 0, 1)});
    plan.push_back('{mk(FUNC_BAD7, 0, 0, 0, 0, 0, 0, 0, 0), 1, gr(0, 0, 0, 1)});
    // fill the pool with protected and unprotected keys, then force evictions
    for (int i = 0; i < 18; i++)
      plan.push_back('{mk(vplsr_pkg::FUNC_ALLOC, 2'((i % 2) ? 1 : 2), 9'(i), 9'(i % 3),
                          0, 0, 0, 0, 0), 0, '0});
    plan.push_back('{mk(vplsr_pkg::FUNC_PRESERVE, 0, 0, 0, 4, 0, 0, 0, 0), 0, '0});
    plan.push_back('{mk(vplsr_pkg::FUNC_ALLOC, 3, 9, 9, 0, 0, 0, 0, 0), 0, '0});
    plan.push_back('{mk(vplsr_pkg::FUNC_DISCARD, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     gr(0, 0, 0, 0)});
    plan.push_back('{mk(vplsr_pkg::FUNC_ALLOC, 1, 0, 0, 0, 0, 0, 0, 0), 1, gr(0, 0, 0, 0)});

    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (plan[i]) begin
      send(plan[i].rq);
      if (plan[i].typed && grants_due[$] != plan[i].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: typed %h predicted %h", i, plan[i].want, grants_due[$]);
      end
    end
    k = 0;
    while (k < 1000) begin
      send(rand_req());
      k++;
    end
    in_tvalid <= 0;
    sending_done = 1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int w;
    out_tready <= 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 0;
      else begin
        w = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) w = 0;
        repeat (w) @(posedge clk);
        out_tready <= 1;
        do @(posedge clk); while (!out_tvalid);
        out_tready <= 0;
      end
    end
  end

  initial begin
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    grant_t exp_g;
    grant_t got_g;
    if (rst_n && out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_tdata);
      end else begin
        exp_g = grants_due.pop_front();
        got_g = '{chosen: out_tdata[3:0], hit: out_tdata[4], replaced: out_tdata[5],
                  refused: out_tdata[6]};
        if (got_g !== exp_g || out_tdata[7] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("slot %0d/%0d hit %b/%b repl %b/%b status %b/%b",
                     exp_g.chosen, out_tdata[3:0], exp_g.hit, out_tdata[4],
                     exp_g.replaced, out_tdata[5], exp_g.refused, out_tdata[6]);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (grants_due.size() != 0 && cycles < LIMIT) @(posedge clk);
    repeat (40) @(posedge clk);
    if (cycles >= LIMIT) $display("FAIL view_priority_lru_slot_replacer_top");
    else if (mismatches == 0 && grants_due.size() == 0)
      $display("PASS view_priority_lru_slot_replacer_top");
    else $display("FAIL view_priority_lru_slot_replacer_top");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT + 100) begin
      $display("FAIL view_priority_lru_slot_replacer_top");
      $finish;
    end
  end
endmodule
